// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the rtl files
// every macro expects clk and arst_n in the scope where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");

`endif

// ----- hw/rtl/skf_pkg.sv -----
// package for the steady-state kalman update core
// types, register indexes, reset values and default widths; no dependencies
package skf_pkg;

	localparam int DEF_FRAC_BITS   = 11;
	localparam int DEF_VALUE_WIDTH = 32;
	localparam int DEF_COEF_WIDTH  = 16;

	localparam int PORT_W  = 32;
	localparam int SLOT_W  = 16;
	localparam int REG_W   = 48;
	localparam int IDX_W   = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_G_ROW0 = 3'd0,
		REG_G_ROW1 = 3'd1,
		REG_G_ROW2 = 3'd2,
		REG_C_ROW0 = 3'd3,
		REG_C_ROW1 = 3'd4,
		REG_K_COL0 = 3'd5,
		REG_K_COL1 = 3'd6
	} reg_idx_t;

	localparam logic [REG_W-1:0] RST_G_ROW0 = 48'd2023;
	localparam logic [REG_W-1:0] RST_G_ROW1 = 48'd134217728;
	localparam logic [REG_W-1:0] RST_G_ROW2 = 48'd8796103573501;
	localparam logic [REG_W-1:0] RST_C_ROW0 = 48'd63488;
	localparam logic [REG_W-1:0] RST_C_ROW1 = 48'd4160749568;
	localparam logic [REG_W-1:0] RST_K_COL0 = 48'd281234412537153;
	localparam logic [REG_W-1:0] RST_K_COL1 = 48'd390917520512;

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_UPDATE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRIOR,
		ST_INNOV,
		ST_CORR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic issue;
		logic first;
	} lane_ctl_t;

	typedef struct packed {
		logic take;
		logic load;
		logic cap_prior;
		logic cap_innov;
		logic cap_corr;
		logic emit;
	} mrg_ctl_t;

endpackage

// ----- hw/rtl/skf_lane.sv -----
// one multiply-accumulate lane: registered product, accumulator, rounding
// depends on skf_pkg for the lane control struct
module skf_lane #(
	parameter int FRAC_BITS   = skf_pkg::DEF_FRAC_BITS,
	parameter int VALUE_WIDTH = skf_pkg::DEF_VALUE_WIDTH,
	parameter int COEF_WIDTH  = skf_pkg::DEF_COEF_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  skf_pkg::lane_ctl_t            ctl,
	input  logic signed [COEF_WIDTH-1:0]  coef,
	input  logic signed [VALUE_WIDTH-1:0] opnd,
	output logic signed [VALUE_WIDTH-1:0] rnd
);

	localparam int PROD_W = VALUE_WIDTH + COEF_WIDTH;
	localparam int ACC_W  = PROD_W + 2;
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

	logic signed [PROD_W-1:0] prod_s1;
	logic                     vld_s1;
	logic                     first_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  biased;
	logic signed [ACC_W-1:0]  shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			first_s1 <= 1'b0;
		end else begin
			vld_s1   <= ctl.issue;
			first_s1 <= ctl.first;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.issue) begin
			prod_s1 <= coef * opnd;
		end
		if (vld_s1) begin
			if (first_s1) begin
				acc_q <= ACC_W'(prod_s1);
			end else begin
				acc_q <= acc_q + ACC_W'(prod_s1);
			end
		end
	end

	// round half up, then wrap
	assign biased  = acc_q + HALF;
	assign shifted = biased >>> FRAC_BITS;
	assign rnd     = shifted[VALUE_WIDTH-1:0];

endmodule

// ----- hw/rtl/skf_merge.sv -----
// merging stage: gathers lane results, vector adds, estimate store, output register
// depends on skf_pkg and assert_macros.svh
`include "assert_macros.svh"

module skf_merge #(
	parameter int VALUE_WIDTH = skf_pkg::DEF_VALUE_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  skf_pkg::mrg_ctl_t             ctl,
	input  logic signed [VALUE_WIDTH-1:0] lane_rnd [3],
	input  logic signed [VALUE_WIDTH-1:0] est_in [3],
	input  logic signed [VALUE_WIDTH-1:0] meas_in [2],
	output logic signed [VALUE_WIDTH-1:0] est [3],
	output logic signed [VALUE_WIDTH-1:0] prior [3],
	output logic signed [VALUE_WIDTH-1:0] innov [2],
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic signed [VALUE_WIDTH-1:0] o_prior [3],
	output logic signed [VALUE_WIDTH-1:0] o_innov [2],
	output logic signed [VALUE_WIDTH-1:0] o_corr [3],
	output logic signed [VALUE_WIDTH-1:0] o_post [3]
);

	logic signed [VALUE_WIDTH-1:0] est_q [3];
	logic signed [VALUE_WIDTH-1:0] prior_q [3];
	logic signed [VALUE_WIDTH-1:0] innov_q [2];
	logic signed [VALUE_WIDTH-1:0] corr_q [3];
	logic signed [VALUE_WIDTH-1:0] meas_q [2];
	logic signed [VALUE_WIDTH-1:0] post_c [3];
	logic                          load_q;
	logic                          out_valid_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			post_c[i] = load_q ? est_q[i] : prior_q[i] + corr_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				est_q[i] <= '0;
			end
			load_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.take) begin
				load_q <= ctl.load;
				if (ctl.load) begin
					est_q <= est_in;
				end
			end
			if (ctl.emit) begin
				est_q       <= post_c;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			meas_q <= meas_in;
			if (ctl.load) begin
				for (int i = 0; i < 3; i++) begin
					prior_q[i] <= '0;
					corr_q[i]  <= '0;
				end
				innov_q[0] <= '0;
				innov_q[1] <= '0;
			end
		end
		if (ctl.cap_prior) begin
			prior_q <= lane_rnd;
		end
		if (ctl.cap_innov) begin
			innov_q[0] <= meas_q[0] + lane_rnd[0];
			innov_q[1] <= meas_q[1] + lane_rnd[1];
		end
		if (ctl.cap_corr) begin
			corr_q <= lane_rnd;
		end
		if (ctl.emit) begin
			o_prior <= prior_q;
			o_innov <= innov_q;
			o_corr  <= corr_q;
			o_post  <= post_c;
		end
	end

	assign est       = est_q;
	assign prior     = prior_q;
	assign innov     = innov_q;
	assign out_valid = out_valid_q;

	`ASSERT_ALWAYS(a_ctl_excl, ($onehot0({ctl.take, ctl.cap_prior, ctl.cap_innov, ctl.cap_corr, ctl.emit})))
	`ASSERT_IMPL(a_emit_free, ctl.emit, (!out_valid_q || !out_stall))

endmodule

// ----- hw/rtl/steady_state_kalman_update_core.sv -----
// top level of the steady-state kalman update core: sequencer, coefficient registers, lanes
// depends on skf_pkg, skf_lane, skf_merge and assert_macros.svh
//
//  channel | signals                        | transfer when
//  --------+--------------------------------+-------------------------
//  in      | in_valid, in_stall, action ... | in_valid && !in_stall
//  out     | out_valid, out_stall, prior0.. | out_valid && !out_stall
//  cfg     | cfg_we, cfg_index, cfg_data    | cfg_we
//
// an update runs the prior, innovation and correction phases in order: three lanes
// share the prior and correction phases and two the innovation phase, one multiply per lane
// per cycle; a load goes straight to the done state; one item is in work at a time, the next
// input transfer is taken once the result sits in the output register
// reset restores the coefficient defaults and clears the estimate
// a stalled output holds the finished item in the done state until it can move
`include "assert_macros.svh"

module steady_state_kalman_update_core #(
	parameter int FRAC_BITS   = skf_pkg::DEF_FRAC_BITS,
	parameter int VALUE_WIDTH = skf_pkg::DEF_VALUE_WIDTH,
	parameter int COEF_WIDTH  = skf_pkg::DEF_COEF_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [skf_pkg::IDX_W-1:0]          cfg_index,
	input  logic [skf_pkg::REG_W-1:0]          cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               action,
	input  logic signed [skf_pkg::PORT_W-1:0]  est0,
	input  logic signed [skf_pkg::PORT_W-1:0]  est1,
	input  logic signed [skf_pkg::PORT_W-1:0]  est2,
	input  logic signed [skf_pkg::PORT_W-1:0]  meas0,
	input  logic signed [skf_pkg::PORT_W-1:0]  meas1,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [skf_pkg::PORT_W-1:0]  prior0,
	output logic signed [skf_pkg::PORT_W-1:0]  prior1,
	output logic signed [skf_pkg::PORT_W-1:0]  prior2,
	output logic signed [skf_pkg::PORT_W-1:0]  innov0,
	output logic signed [skf_pkg::PORT_W-1:0]  innov1,
	output logic signed [skf_pkg::PORT_W-1:0]  corr0,
	output logic signed [skf_pkg::PORT_W-1:0]  corr1,
	output logic signed [skf_pkg::PORT_W-1:0]  corr2,
	output logic signed [skf_pkg::PORT_W-1:0]  post0,
	output logic signed [skf_pkg::PORT_W-1:0]  post1,
	output logic signed [skf_pkg::PORT_W-1:0]  post2
);

	localparam int VW = VALUE_WIDTH;
	localparam int CW = COEF_WIDTH;
	localparam logic [2:0] CNT_N3    = 3'd3;
	localparam logic [2:0] CNT_N2    = 3'd2;
	localparam logic [2:0] CNT_LAST3 = 3'd4;
	localparam logic [2:0] CNT_LAST2 = 3'd3;

	logic [skf_pkg::REG_W-1:0] g_q [3];
	logic [skf_pkg::REG_W-1:0] c_q [2];
	logic [skf_pkg::REG_W-1:0] k_q [2];

	skf_pkg::state_t    state_q, state_d;
	logic [2:0]         cnt_q, cnt_d;
	logic [1:0]         step;
	skf_pkg::lane_ctl_t lctl;
	skf_pkg::mrg_ctl_t  mctl;

	logic signed [CW-1:0] coef [3];
	logic signed [VW-1:0] opnd [3];
	logic signed [VW-1:0] lane_rnd [3];
	logic signed [VW-1:0] est_in [3];
	logic signed [VW-1:0] meas_in [2];
	logic signed [VW-1:0] est [3];
	logic signed [VW-1:0] prior [3];
	logic signed [VW-1:0] innov [2];
	logic signed [VW-1:0] o_prior [3];
	logic signed [VW-1:0] o_innov [2];
	logic signed [VW-1:0] o_corr [3];
	logic signed [VW-1:0] o_post [3];

	function automatic logic signed [CW-1:0] slot_of(input logic [skf_pkg::REG_W-1:0] r,
			input logic [1:0] k);
		logic [skf_pkg::SLOT_W-1:0] s;
		case (k)
			2'd1:    s = r[2*skf_pkg::SLOT_W-1:skf_pkg::SLOT_W];
			2'd2:    s = r[3*skf_pkg::SLOT_W-1:2*skf_pkg::SLOT_W];
			default: s = r[skf_pkg::SLOT_W-1:0];
		endcase
		return s[CW-1:0];
	endfunction

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_q[0] <= skf_pkg::RST_G_ROW0;
			g_q[1] <= skf_pkg::RST_G_ROW1;
			g_q[2] <= skf_pkg::RST_G_ROW2;
			c_q[0] <= skf_pkg::RST_C_ROW0;
			c_q[1] <= skf_pkg::RST_C_ROW1;
			k_q[0] <= skf_pkg::RST_K_COL0;
			k_q[1] <= skf_pkg::RST_K_COL1;
		end else if (cfg_we) begin
			case (cfg_index)
				skf_pkg::REG_G_ROW0: g_q[0] <= cfg_data;
				skf_pkg::REG_G_ROW1: g_q[1] <= cfg_data;
				skf_pkg::REG_G_ROW2: g_q[2] <= cfg_data;
				skf_pkg::REG_C_ROW0: c_q[0] <= cfg_data;
				skf_pkg::REG_C_ROW1: c_q[1] <= cfg_data;
				skf_pkg::REG_K_COL0: k_q[0] <= cfg_data;
				skf_pkg::REG_K_COL1: k_q[1] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skf_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	assign in_stall = (state_q != skf_pkg::ST_IDLE);
	assign step     = cnt_q[1:0];

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		lctl    = '0;
		mctl    = '0;
		case (state_q)
			skf_pkg::ST_IDLE: begin
				if (in_valid) begin
					mctl.take = 1'b1;
					mctl.load = (action == skf_pkg::ACT_LOAD);
					cnt_d     = '0;
					state_d   = (action == skf_pkg::ACT_UPDATE) ? skf_pkg::ST_PRIOR
						: skf_pkg::ST_DONE;
				end
			end
			skf_pkg::ST_PRIOR: begin
				lctl.issue = (cnt_q < CNT_N3);
				lctl.first = (cnt_q == 3'd0);
				cnt_d      = cnt_q + 3'd1;
				if (cnt_q == CNT_LAST3) begin
					mctl.cap_prior = 1'b1;
					cnt_d          = '0;
					state_d        = skf_pkg::ST_INNOV;
				end
			end
			skf_pkg::ST_INNOV: begin
				lctl.issue = (cnt_q < CNT_N3);
				lctl.first = (cnt_q == 3'd0);
				cnt_d      = cnt_q + 3'd1;
				if (cnt_q == CNT_LAST3) begin
					mctl.cap_innov = 1'b1;
					cnt_d          = '0;
					state_d        = skf_pkg::ST_CORR;
				end
			end
			skf_pkg::ST_CORR: begin
				lctl.issue = (cnt_q < CNT_N2);
				lctl.first = (cnt_q == 3'd0);
				cnt_d      = cnt_q + 3'd1;
				if (cnt_q == CNT_LAST2) begin
					mctl.cap_corr = 1'b1;
					cnt_d         = '0;
					state_d       = skf_pkg::ST_DONE;
				end
			end
			skf_pkg::ST_DONE: begin
				if (!out_valid || !out_stall) begin
					mctl.emit = 1'b1;
					state_d   = skf_pkg::ST_IDLE;
				end
			end
			default: state_d = skf_pkg::ST_IDLE;
		endcase
	end

	// operand and coefficient selection per phase
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			coef[i] = '0;
			opnd[i] = '0;
		end
		case (state_q)
			skf_pkg::ST_PRIOR: begin
				for (int i = 0; i < 3; i++) begin
					coef[i] = slot_of(g_q[i], step);
					case (step)
						2'd1:    opnd[i] = est[1];
						2'd2:    opnd[i] = est[2];
						default: opnd[i] = est[0];
					endcase
				end
			end
			skf_pkg::ST_INNOV: begin
				for (int i = 0; i < 2; i++) begin
					coef[i] = slot_of(c_q[i], step);
				end
				for (int i = 0; i < 3; i++) begin
					case (step)
						2'd1:    opnd[i] = prior[1];
						2'd2:    opnd[i] = prior[2];
						default: opnd[i] = prior[0];
					endcase
				end
			end
			skf_pkg::ST_CORR: begin
				for (int i = 0; i < 3; i++) begin
					coef[i] = slot_of(step[0] ? k_q[1] : k_q[0], 2'(i));
					opnd[i] = step[0] ? innov[1] : innov[0];
				end
			end
			default: ;
		endcase
	end

	for (genvar i = 0; i < 3; i++) begin : g_lane
		skf_lane #(
			.FRAC_BITS   (FRAC_BITS),
			.VALUE_WIDTH (VALUE_WIDTH),
			.COEF_WIDTH  (COEF_WIDTH)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (lctl),
			.coef   (coef[i]),
			.opnd   (opnd[i]),
			.rnd    (lane_rnd[i])
		);
	end

	assign est_in[0]  = est0[VW-1:0];
	assign est_in[1]  = est1[VW-1:0];
	assign est_in[2]  = est2[VW-1:0];
	assign meas_in[0] = meas0[VW-1:0];
	assign meas_in[1] = meas1[VW-1:0];

	skf_merge #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (mctl),
		.lane_rnd  (lane_rnd),
		.est_in    (est_in),
		.meas_in   (meas_in),
		.est       (est),
		.prior     (prior),
		.innov     (innov),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.o_prior   (o_prior),
		.o_innov   (o_innov),
		.o_corr    (o_corr),
		.o_post    (o_post)
	);

	assign prior0 = skf_pkg::PORT_W'(o_prior[0]);
	assign prior1 = skf_pkg::PORT_W'(o_prior[1]);
	assign prior2 = skf_pkg::PORT_W'(o_prior[2]);
	assign innov0 = skf_pkg::PORT_W'(o_innov[0]);
	assign innov1 = skf_pkg::PORT_W'(o_innov[1]);
	assign corr0  = skf_pkg::PORT_W'(o_corr[0]);
	assign corr1  = skf_pkg::PORT_W'(o_corr[1]);
	assign corr2  = skf_pkg::PORT_W'(o_corr[2]);
	assign post0  = skf_pkg::PORT_W'(o_post[0]);
	assign post1  = skf_pkg::PORT_W'(o_post[1]);
	assign post2  = skf_pkg::PORT_W'(o_post[2]);

	`ASSERT_NEXT(a_upd_start, (in_valid && !in_stall && action == skf_pkg::ACT_UPDATE), (state_q == skf_pkg::ST_PRIOR))
	`ASSERT_IMPL(a_out_from_done, $rose(out_valid), ($past(state_q) == skf_pkg::ST_DONE))
	`ASSERT_ALWAYS(a_cnt_range, (cnt_q <= CNT_LAST3))

endmodule

// ----- tb/tb_steady_state_kalman_update_core.sv -----
// self-checking testbench for steady_state_kalman_update_core: directed and random loads and
// measurement updates under several coefficient settings, checked against an in-bench predictor
// depends on skf_pkg and the core rtl
module tb_steady_state_kalman_update_core;
	timeunit 1ns;
	timeprecision 1ps;
	import skf_pkg::*;

	localparam int N_REGS = 7;
	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_REPORTS = 40;
	localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;

	typedef struct {
		logic act;
		logic signed [PORT_W-1:0] est [3];
		logic signed [PORT_W-1:0] meas [2];
	} obs_item_t;

	typedef struct {
		logic signed [PORT_W-1:0] prior [3];
		logic signed [PORT_W-1:0] innov [2];
		logic signed [PORT_W-1:0] corr [3];
		logic signed [PORT_W-1:0] post [3];
	} step_result_t;

	class kalman_scoreboard;
		logic [REG_W-1:0] coef_regs [N_REGS];
		logic signed [PORT_W-1:0] est_state [3];
		step_result_t expected_steps [$];
		int errors;

		function new();
			coef_regs[REG_G_ROW0] = RST_G_ROW0;
			coef_regs[REG_G_ROW1] = RST_G_ROW1;
			coef_regs[REG_G_ROW2] = RST_G_ROW2;
			coef_regs[REG_C_ROW0] = RST_C_ROW0;
			coef_regs[REG_C_ROW1] = RST_C_ROW1;
			coef_regs[REG_K_COL0] = RST_K_COL0;
			coef_regs[REG_K_COL1] = RST_K_COL1;
			for (int i = 0; i < 3; i++)
				est_state[i] = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
			if (idx <= REG_K_COL1)
				coef_regs[idx] = val;
		endfunction

		function longint coef(int r, int k);
			logic signed [SLOT_W-1:0] c;
			c = coef_regs[r][k*SLOT_W +: SLOT_W];
			return longint'(c);
		endfunction

		// round half up, arithmetic shift, wrap to the port width
		function logic signed [PORT_W-1:0] round_q(longint acc);
			longint r;
			r = (acc + (longint'(1) << (DEF_FRAC_BITS - 1))) >>> DEF_FRAC_BITS;
			return r[PORT_W-1:0];
		endfunction

		function void note_measurement(obs_item_t it);
			step_result_t r;
			longint acc;
			for (int i = 0; i < 3; i++) begin
				r.prior[i] = '0;
				r.corr[i] = '0;
			end
			r.innov[0] = '0;
			r.innov[1] = '0;
			if (it.act == ACT_LOAD) begin
				for (int i = 0; i < 3; i++) begin
					est_state[i] = it.est[i];
					r.post[i] = it.est[i];
				end
			end else begin
				for (int i = 0; i < 3; i++) begin
					acc = 0;
					for (int k = 0; k < 3; k++)
						acc += coef(REG_G_ROW0 + i, k) * longint'(est_state[k]);
					r.prior[i] = round_q(acc);
				end
				for (int i = 0; i < 2; i++) begin
					acc = 0;
					for (int k = 0; k < 3; k++)
						acc += coef(REG_C_ROW0 + i, k) * longint'(r.prior[k]);
					r.innov[i] = it.meas[i] + round_q(acc);
				end
				for (int i = 0; i < 3; i++) begin
					acc = coef(REG_K_COL0, i) * longint'(r.innov[0])
						+ coef(REG_K_COL1, i) * longint'(r.innov[1]);
					r.corr[i] = round_q(acc);
					r.post[i] = r.prior[i] + r.corr[i];
					est_state[i] = r.post[i];
				end
			end
			expected_steps.push_back(r);
		endfunction

		function void cmp(string name, logic signed [PORT_W-1:0] want,
				logic signed [PORT_W-1:0] got);
			if (got !== want) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t %s mismatch: expected %0d, actual %0d", $time, name,
						want, got);
			end
		endfunction

		function void check_estimate(step_result_t got);
			step_result_t want;
			if (expected_steps.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t unexpected result: expected none, actual post0 %0d",
						$time, got.post[0]);
				return;
			end
			want = expected_steps.pop_front();
			cmp("prior0", want.prior[0], got.prior[0]);
			cmp("prior1", want.prior[1], got.prior[1]);
			cmp("prior2", want.prior[2], got.prior[2]);
			cmp("innov0", want.innov[0], got.innov[0]);
			cmp("innov1", want.innov[1], got.innov[1]);
			cmp("corr0", want.corr[0], got.corr[0]);
			cmp("corr1", want.corr[1], got.corr[1]);
			cmp("corr2", want.corr[2], got.corr[2]);
			cmp("post0", want.post[0], got.post[0]);
			cmp("post1", want.post[1], got.post[1]);
			cmp("post2", want.post[2], got.post[2]);
		endfunction

		function int pending();
			return expected_steps.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic action = ACT_LOAD;
	logic signed [PORT_W-1:0] est0 = '0, est1 = '0, est2 = '0, meas0 = '0, meas1 = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [PORT_W-1:0] prior0, prior1, prior2, innov0, innov1;
	logic signed [PORT_W-1:0] corr0, corr1, corr2, post0, post1, post2;

	kalman_scoreboard sb;
	logic [REG_W-1:0] reg_plan [N_REGS];
	bit sender_gaps = 1'b1;
	bit quiet = 1'b0;
	bit long_hold = 1'b0;
	int idle_cycles = 0;
	step_result_t seen;

	steady_state_kalman_update_core uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .action(action),
		.est0(est0), .est1(est1), .est2(est2), .meas0(meas0), .meas1(meas1),
		.out_valid(out_valid), .out_stall(out_stall),
		.prior0(prior0), .prior1(prior1), .prior2(prior2),
		.innov0(innov0), .innov1(innov1),
		.corr0(corr0), .corr1(corr1), .corr2(corr2),
		.post0(post0), .post1(post1), .post2(post2)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic obs_item_t mk(logic act, logic signed [PORT_W-1:0] e0,
			logic signed [PORT_W-1:0] e1, logic signed [PORT_W-1:0] e2,
			logic signed [PORT_W-1:0] m0, logic signed [PORT_W-1:0] m1);
		obs_item_t it;
		it.act = act;
		it.est[0] = e0;
		it.est[1] = e1;
		it.est[2] = e2;
		it.meas[0] = m0;
		it.meas[1] = m1;
		return it;
	endfunction

	function automatic logic signed [PORT_W-1:0] rand_word();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			return $urandom_range(0, 32767) - 16384;
		if (pick < 8)
			return $urandom;
		if (pick == 8)
			return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
		return $urandom_range(0, 1) ? 32'sh0 : -32'sd1;
	endfunction

	function automatic obs_item_t rand_item();
		return mk(($urandom_range(0, 3) != 0) ? ACT_UPDATE : ACT_LOAD,
			rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
	endfunction

	function automatic logic [SLOT_W-1:0] rand_slot();
		int pick;
		pick = $urandom_range(0, 5);
		if (pick < 3)
			return SLOT_W'($urandom_range(0, 8191) - 4096);
		if (pick < 5)
			return SLOT_W'($urandom);
		return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
	endfunction

	task automatic plan_uniform(input logic [SLOT_W-1:0] slot);
		for (int i = 0; i < N_REGS; i++)
			reg_plan[i] = {slot, slot, slot};
	endtask

	task automatic plan_random();
		for (int i = 0; i < N_REGS; i++)
			reg_plan[i] = {rand_slot(), rand_slot(), rand_slot()};
	endtask

	task automatic plan_defaults();
		reg_plan[REG_G_ROW0] = RST_G_ROW0;
		reg_plan[REG_G_ROW1] = RST_G_ROW1;
		reg_plan[REG_G_ROW2] = RST_G_ROW2;
		reg_plan[REG_C_ROW0] = RST_C_ROW0;
		reg_plan[REG_C_ROW1] = RST_C_ROW1;
		reg_plan[REG_K_COL0] = RST_K_COL0;
		reg_plan[REG_K_COL1] = RST_K_COL1;
	endtask

	task automatic program_regs(input bit poke_spare);
		logic [REG_W-1:0] junk;
		for (int i = 0; i < N_REGS; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= reg_idx_t'(i);
			cfg_data <= reg_plan[i];
			@(posedge clk);
			sb.write_reg(reg_idx_t'(i), reg_plan[i]);
		end
		if (poke_spare) begin
			junk[47:32] = 16'($urandom);
			junk[31:0] = $urandom;
			cfg_we <= 1'b1;
			cfg_index <= REG_SPARE;
			cfg_data <= junk;
			@(posedge clk);
			sb.write_reg(REG_SPARE, junk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_item(input obs_item_t it);
		in_valid <= 1'b1;
		action <= it.act;
		est0 <= it.est[0];
		est1 <= it.est[1];
		est2 <= it.est[2];
		meas0 <= it.meas[0];
		meas1 <= it.meas[1];
		do
			@(posedge clk);
		while (in_stall);
		sb.note_measurement(it);
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic send_random(input int count);
		repeat (count) send_item(rand_item());
	endtask

	// let the core go idle before touching the coefficients
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// receiver side: random stall bursts, one long hold on request, none at the end
	initial begin
		wait (arst_n);
		forever begin
			if (quiet) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else if (long_hold) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				long_hold = 1'b0;
				@(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 120) :
					$urandom_range(1, 12)) @(posedge clk);
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
		end
	end

	// result checking and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				seen.prior[0] = prior0;
				seen.prior[1] = prior1;
				seen.prior[2] = prior2;
				seen.innov[0] = innov0;
				seen.innov[1] = innov1;
				seen.corr[0] = corr0;
				seen.corr[1] = corr1;
				seen.corr[2] = corr2;
				seen.post[0] = post0;
				seen.post[1] = post1;
				seen.post[2] = post2;
				sb.check_estimate(seen);
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_steady_state_kalman_update_core: FAIL");
				$finish;
			end
		end
	end

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset estimate, field extremes, both actions
		send_item(mk(ACT_UPDATE, 0, 0, 0, 32'sd1000, -32'sd1000));
		send_item(mk(ACT_LOAD, 0, 0, 0, 0, 0));
		send_item(mk(ACT_UPDATE, 0, 0, 0, 0, 0));
		send_item(mk(ACT_LOAD, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0));
		send_item(mk(ACT_UPDATE, 0, 0, 0, 32'sh7fffffff, 32'sh7fffffff));
		send_item(mk(ACT_LOAD, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0));
		send_item(mk(ACT_UPDATE, 0, 0, 0, 32'sh80000000, 32'sh80000000));
		send_item(mk(ACT_LOAD, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1));
		send_item(mk(ACT_UPDATE, -32'sd1, -32'sd1, -32'sd1, -32'sd1, 32'sd1));
		send_item(mk(ACT_LOAD, 32'sd2048, -32'sd2048, 32'sd4096, 0, 0));
		send_item(mk(ACT_UPDATE, 0, 0, 0, 32'sd2048, -32'sd2048));
		send_item(mk(ACT_UPDATE, 0, 0, 0, 0, 0));
		send_item(mk(ACT_UPDATE, 0, 0, 0, 32'sh7fffffff, 32'sh80000000));
		send_item(mk(ACT_LOAD, 32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f, 0, 0));
		send_item(mk(ACT_UPDATE, 32'sh12345678, 0, 0, 32'sh55555555, 32'shaaaaaaaa));
		send_item(mk(ACT_LOAD, 32'sh7fffffff, 32'sh80000000, -32'sd1, 0, 0));
		send_item(mk(ACT_UPDATE, 0, 0, 0, 32'sh80000000, 32'sh7fffffff));
		send_random(300);

		drain();
		plan_uniform(16'h7fff);
		program_regs(1'b0);
		send_item(mk(ACT_LOAD, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0));
		send_item(mk(ACT_UPDATE, 0, 0, 0, 32'sh7fffffff, 32'sh7fffffff));
		send_random(150);

		drain();
		plan_uniform(16'h8000);
		program_regs(1'b1);
		send_item(mk(ACT_LOAD, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0));
		send_item(mk(ACT_UPDATE, 0, 0, 0, 32'sh80000000, 32'sh80000000));
		send_random(150);

		drain();
		plan_uniform(16'h0000);
		program_regs(1'b0);
		send_random(100);

		drain();
		plan_uniform(16'hffff);
		program_regs(1'b1);
		send_random(100);

		repeat (4) begin
			drain();
			plan_random();
			program_regs($urandom_range(0, 1));
			send_random(150);
		end

		// back-pressure: receiver holds off while the sender keeps offering
		drain();
		plan_defaults();
		program_regs(1'b0);
		sender_gaps = 1'b0;
		long_hold = 1'b1;
		send_random(300);

		drain();
		plan_random();
		program_regs(1'b0);
		quiet = 1'b1;
		send_random(200);

		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb_steady_state_kalman_update_core: PASS");
		else
			$display("tb_steady_state_kalman_update_core: FAIL");
		$finish;
	end
endmodule
